// File: hdl/vfd_pkg.sv
// Shared constants, codes and types of the VADPCM frame decoder.
`timescale 1ns / 1ps
`default_nettype none

package vfd_pkg;

   localparam int NUM_PREDICTORS_DEFAULT = 8;

   localparam int ACTION_W  = 2;
   localparam int INDEX_W   = 7;
   localparam int SAMPLE_W  = 16;
   localparam int BYTE_W    = 8;
   localparam int NIB_W     = 4;
   localparam int GROUP_N   = 8;                 // samples per group
   localparam int TAPS      = 16;                // coefficients per predictor
   localparam int NIBS_W    = GROUP_N * NIB_W;   // packed codes of one group
   localparam int QUEUE_DEPTH = 4;

   // input action codes
   localparam logic [ACTION_W-1:0] ACT_LOAD   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_HIST   = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_DECODE = 2'd2;

   typedef enum logic [1:0] {
      CMD_LOAD,
      CMD_HIST,
      CMD_GROUP
   } cmd_op_type;

   // one queued command; data holds the coefficient, {newer, older} or the codes
   typedef struct packed {
      cmd_op_type          op;
      logic [INDEX_W-1:0]  index;
      logic [NIBS_W-1:0]   data;
      logic [NIB_W-1:0]    shift;
      logic [NIB_W-1:0]    pred;
      logic                frame_last;
   } cmd_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_MAC,
      BK_DONE
   } back_state_type;

endpackage

`default_nettype wire

// File: hdl/vfd_channel_if.sv
// Request and response channel interfaces of the VADPCM frame decoder.
`timescale 1ns / 1ps
`default_nettype none

interface vfd_req_if import vfd_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [ACTION_W-1:0]        action;
   logic [INDEX_W-1:0]         coef_index;
   logic signed [SAMPLE_W-1:0] coef_value;
   logic signed [SAMPLE_W-1:0] history_newer;
   logic signed [SAMPLE_W-1:0] history_older;
   logic [BYTE_W-1:0]          data_byte;

   modport source (output valid, action, coef_index, coef_value, history_newer,
                   history_older, data_byte, input ready);
   modport sink   (input valid, action, coef_index, coef_value, history_newer,
                   history_older, data_byte, output ready);
endinterface

interface vfd_rsp_if import vfd_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] pcm_sample;
   logic                       group_last;
   logic                       frame_last;

   modport source (output valid, pcm_sample, group_last, frame_last, input ready);
   modport sink   (input valid, pcm_sample, group_last, frame_last, output ready);
endinterface

`default_nettype wire

// File: hdl/vfd_front.sv
// Front end: accepts request beats, tracks the frame and queues commands.
`timescale 1ns / 1ps
`default_nettype none

module vfd_front import vfd_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   vfd_req_if.sink     req_bus,
   output logic        q_valid,
   output cmd_type     q_cmd,
   input  wire logic   q_ready
);

   logic [3:0]        byte_pos_ff, byte_pos_in;
   logic [NIB_W-1:0]  shift_ff, shift_in;
   logic [NIB_W-1:0]  pred_ff, pred_in;
   logic [NIBS_W-1:0] nib_ff;
   logic [NIBS_W-1:0] nib_new;
   logic [3:0]        pos_minus;
   logic [1:0]        slot;
   logic              is_header;
   logic              group_done;
   logic              need_push;
   logic              accept;

   assign accept        = req_bus.valid && req_bus.ready;
   assign req_bus.ready = q_ready;

   always_comb begin
      is_header  = (byte_pos_ff == 4'd0) || (byte_pos_ff > 4'd8);
      pos_minus  = byte_pos_ff - 4'd1;
      slot       = pos_minus[1:0];
      group_done = !is_header && ((byte_pos_ff == 4'd4) || (byte_pos_ff == 4'd8));

      nib_new = nib_ff;
      for (int s = 0; s < GROUP_N / 2; s++) begin
         if (slot == 2'(s)) begin
            // high nibble is the earlier code
            nib_new[2*NIB_W*s +: 2*NIB_W] = {req_bus.data_byte[3:0],
                                             req_bus.data_byte[7:4]};
         end
      end

      need_push = 1'b0;
      q_cmd.op  = CMD_LOAD;
      q_cmd.data = '0;
      priority if (req_bus.action == ACT_LOAD) begin
         need_push  = 1'b1;
         q_cmd.op   = CMD_LOAD;
         q_cmd.data = NIBS_W'(unsigned'(req_bus.coef_value));
      end else if (req_bus.action == ACT_HIST) begin
         need_push  = 1'b1;
         q_cmd.op   = CMD_HIST;
         q_cmd.data = {req_bus.history_newer, req_bus.history_older};
      end else if (req_bus.action == ACT_DECODE) begin
         need_push  = group_done;
         q_cmd.op   = CMD_GROUP;
         q_cmd.data = nib_new;
      end else begin
         need_push = 1'b0;
      end
      q_cmd.index      = req_bus.coef_index;
      q_cmd.shift      = shift_ff;
      q_cmd.pred       = pred_ff;
      q_cmd.frame_last = (byte_pos_ff == 4'd8);
      q_valid          = req_bus.valid && need_push;

      byte_pos_in = byte_pos_ff;
      shift_in    = shift_ff;
      pred_in     = pred_ff;
      if (accept) begin
         if (req_bus.action == ACT_HIST) begin
            byte_pos_in = 4'd0;
         end else if (req_bus.action == ACT_DECODE) begin
            if (is_header) begin
               shift_in    = req_bus.data_byte[7:4];
               pred_in     = req_bus.data_byte[3:0];
               byte_pos_in = 4'd1;
            end else if (byte_pos_ff == 4'd8) begin
               byte_pos_in = 4'd0;
            end else begin
               byte_pos_in = byte_pos_ff + 4'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_pos_ff <= 4'd0;
         shift_ff    <= '0;
         pred_ff     <= '0;
      end else begin
         byte_pos_ff <= byte_pos_in;
         shift_ff    <= shift_in;
         pred_ff     <= pred_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (req_bus.action == ACT_DECODE) && !is_header) begin
         nib_ff <= nib_new;
      end
   end

endmodule

`default_nettype wire

// File: hdl/vfd_queue.sv
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module vfd_queue import vfd_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push_valid,
   input  wire cmd_type push_cmd,
   output logic         push_ready,
   output logic         pop_valid,
   output cmd_type      pop_cmd,
   input  wire logic    pop_ready
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_cmd;
   end

endmodule

`default_nettype wire

// File: hdl/vfd_back.sv
// Back end: codebook memory, eight-lane predictor MAC and sample output buffer.
`timescale 1ns / 1ps
`default_nettype none

module vfd_back import vfd_pkg::*; #(
   parameter int NUM_PREDICTORS = NUM_PREDICTORS_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    cmd_valid,
   input  wire cmd_type cmd,
   output logic         cmd_ready,
   vfd_rsp_if.source    rsp_bus
);

   localparam int ROW_W     = (NUM_PREDICTORS > 1) ? $clog2(NUM_PREDICTORS) : 1;
   localparam int BOOK_SIZE = NUM_PREDICTORS * TAPS;
   localparam int ACC_W     = 36;
   localparam int FRAC_BITS = 11;
   localparam int PROD_W    = 2 * SAMPLE_W;
   localparam logic [3:0] LAST_STEP = 4'd9;   // 9 products, last one accumulates here
   localparam logic [8:0] BOOK_LIMIT = 9'(BOOK_SIZE);
   localparam logic [4:0] PRED_LIMIT = 5'(NUM_PREDICTORS);
   localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32767);
   localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(32768);

   // codebook: one row per predictor, both orders side by side
   logic [TAPS-1:0][SAMPLE_W-1:0] book_mem [NUM_PREDICTORS];
   logic [TAPS-1:0][SAMPLE_W-1:0] row_ff;
   logic [NUM_PREDICTORS-1:0]     row_valid_ff;
   logic                          coef_zero_ff;

   back_state_type state_ff, state_in;
   logic [3:0]     step_ff;

   logic [NIBS_W-1:0] nib_ff;
   logic [NIB_W-1:0]  shift_ff;
   logic              last_ff;

   logic signed [SAMPLE_W-1:0] older_ff, newer_ff;

   logic signed [SAMPLE_W-1:0] coef0   [GROUP_N];
   logic signed [SAMPLE_W-1:0] coef1   [GROUP_N];
   logic signed [SAMPLE_W-1:0] nib_ext [GROUP_N];
   logic signed [SAMPLE_W-1:0] xs      [GROUP_N];
   logic signed [SAMPLE_W-1:0] mul_a   [GROUP_N];
   logic signed [SAMPLE_W-1:0] mul_b   [GROUP_N];
   logic [2:0]                 tap_idx [GROUP_N];
   logic signed [PROD_W-1:0]   prod_ff [GROUP_N];
   logic signed [ACC_W-1:0]    acc_ff  [GROUP_N];
   logic signed [ACC_W-1:0]    acc_sh  [GROUP_N];
   logic signed [SAMPLE_W-1:0] sat_s   [GROUP_N];
   logic [2:0]                 kk;

   logic signed [SAMPLE_W-1:0] obuf_ff [GROUP_N];
   logic [2:0]                 oidx_ff;
   logic                       obusy_ff;
   logic                       olast_ff;
   logic                       rsp_take;
   logic                       obuf_free;

   logic             do_load, do_hist, do_group, obuf_load;
   logic [3:0]       load_row4;
   logic [ROW_W-1:0] wr_row, rd_row;
   logic [3:0]       tap;
   logic             load_ok, pred_ok;

   // ---- command decode and sequencing ----
   always_comb begin
      load_row4 = {1'b0, cmd.index[6:4]};
      wr_row    = load_row4[ROW_W-1:0];
      tap       = cmd.index[3:0];
      load_ok   = ({2'b00, cmd.index} < BOOK_LIMIT);
      pred_ok   = ({1'b0, cmd.pred} < PRED_LIMIT);
      rd_row    = pred_ok ? cmd.pred[ROW_W-1:0] : '0;
   end

   assign rsp_take  = rsp_bus.valid && rsp_bus.ready;
   assign obuf_free = !obusy_ff || (rsp_take && (oidx_ff == 3'd7));

   always_ff @(posedge clock) begin
      if (reset) state_ff <= BK_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in  = state_ff;
      cmd_ready = 1'b0;
      do_load   = 1'b0;
      do_hist   = 1'b0;
      do_group  = 1'b0;
      obuf_load = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               unique case (cmd.op)
                  CMD_LOAD:  do_load = load_ok;
                  CMD_HIST:  do_hist = 1'b1;
                  CMD_GROUP: begin
                     do_group = 1'b1;
                     state_in = BK_MAC;
                  end
                  default: ;
               endcase
            end
         end
         BK_MAC: begin
            if (step_ff == LAST_STEP) state_in = BK_DONE;
         end
         BK_DONE: begin
            if (obuf_free) begin
               obuf_load = 1'b1;
               state_in  = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // ---- codebook memory ----
   always_ff @(posedge clock) begin
      if (do_load) begin
         for (int i = 0; i < TAPS; i++) begin
            // a row never written reads zero, so its first write clears the rest
            if ((tap == 4'(i)) || !row_valid_ff[wr_row]) begin
               book_mem[wr_row][i] <= (tap == 4'(i)) ? cmd.data[SAMPLE_W-1:0] : '0;
            end
         end
      end
      if (do_group) row_ff <= book_mem[rd_row];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (do_load) begin
         row_valid_ff[wr_row] <= 1'b1;
      end
   end

   // ---- job registers ----
   always_ff @(posedge clock) begin
      if (do_group) begin
         nib_ff       <= cmd.data;
         shift_ff     <= cmd.shift;
         last_ff      <= cmd.frame_last;
         coef_zero_ff <= !pred_ok || !row_valid_ff[rd_row];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else if (state_ff == BK_MAC) begin
         step_ff <= step_ff + 4'd1;
      end else begin
         step_ff <= '0;
      end
   end

   // ---- lane operands ----
   always_comb begin
      kk = 3'(step_ff - 4'd2);
      for (int j = 0; j < GROUP_N; j++) begin
         coef0[j]   = coef_zero_ff ? '0 : $signed(row_ff[j]);
         coef1[j]   = coef_zero_ff ? '0 : $signed(row_ff[GROUP_N + j]);
         nib_ext[j] = {{(SAMPLE_W - NIB_W){nib_ff[NIB_W*j + NIB_W - 1]}},
                       nib_ff[NIB_W*j +: NIB_W]};
         xs[j]      = nib_ext[j] << shift_ff;   // wraps to 16 bits
      end
      for (int j = 0; j < GROUP_N; j++) begin
         tap_idx[j] = 3'(j) - kk - 3'd1;
         if (step_ff == 4'd0) begin
            mul_a[j] = coef0[j];
            mul_b[j] = older_ff;
         end else if (step_ff == 4'd1) begin
            mul_a[j] = coef1[j];
            mul_b[j] = newer_ff;
         end else if ({1'b0, kk} < 4'(j)) begin
            // causal term from code kk into sample j
            mul_a[j] = coef1[tap_idx[j]];
            mul_b[j] = xs[kk];
         end else begin
            mul_a[j] = '0;
            mul_b[j] = '0;
         end
      end
   end

   // ---- MAC lanes: product register, then accumulate ----
   always_ff @(posedge clock) begin
      for (int j = 0; j < GROUP_N; j++) begin
         prod_ff[j] <= mul_a[j] * mul_b[j];
         if (state_ff == BK_MAC) begin
            if (step_ff == 4'd0) begin
               acc_ff[j] <= ACC_W'(xs[j]) <<< FRAC_BITS;
            end else begin
               acc_ff[j] <= acc_ff[j] + ACC_W'(prod_ff[j]);
            end
         end
      end
   end

   always_comb begin
      for (int j = 0; j < GROUP_N; j++) begin
         acc_sh[j] = acc_ff[j] >>> FRAC_BITS;   // floor
         if (acc_sh[j] > SAT_MAX) begin
            sat_s[j] = 16'sh7fff;
         end else if (acc_sh[j] < SAT_MIN) begin
            sat_s[j] = -16'sh8000;
         end else begin
            sat_s[j] = acc_sh[j][SAMPLE_W-1:0];
         end
      end
   end

   // ---- history ----
   always_ff @(posedge clock) begin
      if (reset) begin
         older_ff <= '0;
         newer_ff <= '0;
      end else if (do_hist) begin
         newer_ff <= cmd.data[2*SAMPLE_W-1:SAMPLE_W];
         older_ff <= cmd.data[SAMPLE_W-1:0];
      end else if (obuf_load) begin
         older_ff <= sat_s[GROUP_N-2];
         newer_ff <= sat_s[GROUP_N-1];
      end
   end

   // ---- output buffer ----
   always_ff @(posedge clock) begin
      if (reset) begin
         obusy_ff <= 1'b0;
         oidx_ff  <= '0;
      end else begin
         if (rsp_take) begin
            if (oidx_ff == 3'd7) obusy_ff <= 1'b0;
            oidx_ff <= oidx_ff + 3'd1;
         end
         if (obuf_load) begin
            obusy_ff <= 1'b1;
            oidx_ff  <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (obuf_load) begin
         obuf_ff  <= sat_s;
         olast_ff <= last_ff;
      end
   end

   assign rsp_bus.valid      = obusy_ff;
   assign rsp_bus.pcm_sample = obuf_ff[oidx_ff];
   assign rsp_bus.group_last = (oidx_ff == 3'd7);
   assign rsp_bus.frame_last = (oidx_ff == 3'd7) && olast_ff;

endmodule

`default_nettype wire

// File: hdl/vadpcm_frame_decoder.sv
// Top level of the VADPCM frame decoder: front end, command queue and back end.
`timescale 1ns / 1ps
`default_nettype none

// VADPCM frame decoder. Request beats carry one of three actions: load one
// codebook coefficient (index = predictor*16 + order*8 + tap), set the two
// history samples and restart the frame, or decode one frame byte (header
// with shift in the high nibble and predictor in the low nibble, then eight
// code bytes, high nibble first). After every fourth code byte the block
// returns eight saturated 16-bit samples, with group_last on the eighth and
// frame_last on the eighth of the second group. Predictors at or past
// NUM_PREDICTORS decode with all-zero coefficients; loads past the codebook
// are dropped, action 3 is ignored. Timing: the front end takes one request
// beat per cycle while its 4-entry command queue has room; header and
// non-final code bytes never queue. Each group passes the back end through
// queue pop with codebook row read, the eight-lane multiply-accumulate over
// nine terms, then saturation and output buffer load, which waits until the
// eight samples of the previous group have left; the MAC overlaps them.
// The back end takes no new command until its group is in the output buffer.
// Loads and history beats are taken in the back end's idle state.
// Codebook rows reset to zero through per-row valid bits; no clear pass.

module vadpcm_frame_decoder import vfd_pkg::*; #(
   parameter int NUM_PREDICTORS = NUM_PREDICTORS_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   vfd_req_if.sink    req_bus,
   vfd_rsp_if.source  rsp_bus
);

   // front to queue
   logic    push_valid;
   cmd_type push_cmd;
   logic    push_ready;

   // queue to back
   logic    pop_valid;
   cmd_type pop_cmd;
   logic    pop_ready;

   vfd_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .q_valid (push_valid),
      .q_cmd   (push_cmd),
      .q_ready (push_ready)
   );

   vfd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd),
      .pop_ready  (pop_ready)
   );

   vfd_back #(
      .NUM_PREDICTORS (NUM_PREDICTORS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (pop_valid),
      .cmd       (pop_cmd),
      .cmd_ready (pop_ready),
      .rsp_bus   (rsp_bus)
   );

endmodule

`default_nettype wire

// File: dv/tb.sv
// Self-checking testbench of the VADPCM frame decoder.
`timescale 1ns / 1ps

module tb import vfd_pkg::*; ();

   // ---------------------------------------------------------------------
   // Constants
   // ---------------------------------------------------------------------
   localparam int NUM_PRED  = NUM_PREDICTORS_DEFAULT;
   localparam int BOOK_SIZE = NUM_PRED * TAPS;
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;   // ignored by the block
   localparam int FIRST_GROUP_END = 4;                  // code bytes in group one
   localparam int FRAME_END       = 8;                  // code bytes in a frame
   localparam int SCALE_Q         = 11;                 // fixed-point fraction bits
   localparam int RANDOM_ITEMS    = 250;
   localparam int HOLD_AT_BEAT    = 60;                 // when the long rx hold starts
   localparam int HOLD_CYCLES     = 400;
   localparam int END_SETTLE      = 40;
   localparam int CYCLE_LIMIT     = 200000;

   // one request beat plus its pacing
   typedef struct {
      logic [ACTION_W-1:0]        action;
      logic [INDEX_W-1:0]         coef_index;
      logic signed [SAMPLE_W-1:0] coef_value;
      logic signed [SAMPLE_W-1:0] history_newer;
      logic signed [SAMPLE_W-1:0] history_older;
      logic [BYTE_W-1:0]          data_byte;
      int unsigned                gap;     // idle cycles after this beat
      bit                         drain;   // hold until all pcm has come back
   } req_beat_type;

   typedef struct {
      logic signed [SAMPLE_W-1:0] pcm;
      logic                       group_last;
      logic                       frame_last;
   } pcm_beat_type;

   // ---------------------------------------------------------------------
   // Clock, reset, channels, DUT
   // ---------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   vfd_req_if req_if ();
   vfd_rsp_if rsp_if ();

   vadpcm_frame_decoder u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if)
   );

   // ---------------------------------------------------------------------
   // Shared bookkeeping
   // ---------------------------------------------------------------------
   req_beat_type pending_beats[$];    // stimulus not yet on the bus
   pcm_beat_type pcm_expected[$];     // predicted samples, oldest first
   req_beat_type cur_req;             // beat currently offered
   int unsigned issued_count  = 0;    // beats put on the bus
   int unsigned accept_count  = 0;    // beats taken by the block
   int unsigned items_pushed  = 0;
   int unsigned real_items    = 0;    // excludes ignored action beats
   int unsigned beat_count    = 0;    // pcm beats received
   int unsigned errors        = 0;
   int unsigned cycle_count   = 0;
   bit          burst_mode    = 1'b0; // no sender gaps while set
   bit          drain_next    = 1'b0;

   // ---------------------------------------------------------------------
   // Decoder model state
   // ---------------------------------------------------------------------
   logic signed [SAMPLE_W-1:0] book [BOOK_SIZE];
   logic signed [SAMPLE_W-1:0] hist_newer;
   logic signed [SAMPLE_W-1:0] hist_older;
   int unsigned                frame_pos;
   logic [NIB_W-1:0]           scale;
   logic [NIB_W-1:0]           pred_sel;
   logic [NIB_W-1:0]           codes [GROUP_N];

   // Coefficient lookup; predictors past the codebook read as zero.
   function automatic longint book_coef(input int order, input int tap);
      int idx;
      if (pred_sel >= NUM_PRED)
         return 0;
      idx = int'(pred_sel) * TAPS + order * GROUP_N + tap;
      if (idx >= BOOK_SIZE)
         return 0;
      return longint'(book[idx]);
   endfunction

   // Eight samples from the buffered codes. Older/newer are frozen copies:
   // the live history is updated on samples six and seven.
   task automatic decode_group(input bit last_of_frame);
      logic signed [SAMPLE_W-1:0] x [GROUP_N];
      logic signed [SAMPLE_W-1:0] older;
      logic signed [SAMPLE_W-1:0] newer;
      longint                     acc;
      longint                     s;
      pcm_beat_type               pb;
      older = hist_older;
      newer = hist_newer;
      for (int j = 0; j < GROUP_N; j++)
         // scaled code wraps at 16 bits
         x[j] = {{(SAMPLE_W-NIB_W){codes[j][NIB_W-1]}}, codes[j]} << scale;
      for (int j = 0; j < GROUP_N; j++) begin
         acc = book_coef(0, j) * longint'(older) + book_coef(1, j) * longint'(newer)
             + (longint'(x[j]) <<< SCALE_Q);
         for (int k = 0; k < j; k++)
            acc += book_coef(1, j - k - 1) * longint'(x[k]);
         s = acc >>> SCALE_Q;   // floor
         if (s < -32768)
            s = -32768;
         else if (s > 32767)
            s = 32767;
         pb.pcm        = s[SAMPLE_W-1:0];
         pb.group_last = (j == GROUP_N - 1);
         pb.frame_last = (j == GROUP_N - 1) && last_of_frame;
         pcm_expected.push_back(pb);
         if (j == GROUP_N - 2)
            hist_older = s[SAMPLE_W-1:0];
         if (j == GROUP_N - 1)
            hist_newer = s[SAMPLE_W-1:0];
      end
   endtask

   // Advance the model by one accepted request beat.
   task automatic predict_pcm(input req_beat_type b);
      int slot;
      case (b.action)
         ACT_LOAD: begin
            if (int'(b.coef_index) < BOOK_SIZE)
               book[b.coef_index] = b.coef_value;
         end
         ACT_HIST: begin
            hist_newer = b.history_newer;
            hist_older = b.history_older;
            frame_pos  = 0;
         end
         ACT_DECODE: begin
            if (frame_pos == 0 || frame_pos > FRAME_END) begin
               // header byte
               scale     = b.data_byte[7:4];
               pred_sel  = b.data_byte[3:0];
               frame_pos = 1;
            end else begin
               slot = ((frame_pos - 1) % FIRST_GROUP_END) * 2;
               codes[slot]     = b.data_byte[7:4];
               codes[slot + 1] = b.data_byte[3:0];
               if (frame_pos == FIRST_GROUP_END) begin
                  frame_pos = FIRST_GROUP_END + 1;
                  decode_group(1'b0);
               end else if (frame_pos == FRAME_END) begin
                  frame_pos = 0;
                  decode_group(1'b1);
               end else begin
                  frame_pos++;
               end
            end
         end
         default: ;   // unused action: no effect
      endcase
   endtask

   task automatic report_mismatch(input string msg);
      errors++;
      $display("[%0d] mismatch: %s", cycle_count, msg);
   endtask

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic push_beat(input logic [ACTION_W-1:0] act, input logic [INDEX_W-1:0] idx,
                            input logic [SAMPLE_W-1:0] val, input logic [SAMPLE_W-1:0] nw,
                            input logic [SAMPLE_W-1:0] od, input logic [BYTE_W-1:0] db);
      req_beat_type b;
      b.action        = act;
      b.coef_index    = idx;
      b.coef_value    = val;
      b.history_newer = nw;
      b.history_older = od;
      b.data_byte     = db;
      b.gap           = burst_mode ? 0 : $urandom_range(0, 4);
      b.drain         = drain_next;
      drain_next      = 1'b0;
      pending_beats.push_back(b);
      items_pushed++;
      if (act != ACT_UNUSED)
         real_items++;
   endtask

   // unused fields of each beat carry random junk
   task automatic push_load(input logic [INDEX_W-1:0] idx, input logic [SAMPLE_W-1:0] val);
      push_beat(ACT_LOAD, idx, val, SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                BYTE_W'($urandom));
   endtask

   task automatic push_hist(input logic [SAMPLE_W-1:0] nw, input logic [SAMPLE_W-1:0] od);
      push_beat(ACT_HIST, INDEX_W'($urandom), SAMPLE_W'($urandom), nw, od,
                BYTE_W'($urandom));
   endtask

   task automatic push_byte(input logic [BYTE_W-1:0] db);
      push_beat(ACT_DECODE, INDEX_W'($urandom), SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                SAMPLE_W'($urandom), db);
   endtask

   task automatic push_noise();
      push_beat(ACT_UNUSED, INDEX_W'($urandom), SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                SAMPLE_W'($urandom), BYTE_W'($urandom));
   endtask

   // Realistic coefficients most of the time, extremes and full range too.
   function automatic logic [SAMPLE_W-1:0] rand_coef();
      int r;
      r = $urandom_range(0, 7);
      if (r < 4)
         return SAMPLE_W'($urandom_range(0, 8192) - 4096);
      else if (r < 6)
         return SAMPLE_W'($urandom);
      else if (r == 6)
         return 16'h7fff;
      else
         return 16'h8000;
   endfunction

   function automatic logic [SAMPLE_W-1:0] rand_sample();
      if ($urandom_range(0, 1))
         return SAMPLE_W'($urandom);
      return SAMPLE_W'($urandom_range(0, 2000) - 1000);
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus and end of run
   // ---------------------------------------------------------------------
   initial begin : stim
      int r;
      int n;
      logic [NIB_W-1:0] sh;
      logic [NIB_W-1:0] pd;

      req_if.valid         = 1'b0;
      req_if.action        = ACT_LOAD;
      req_if.coef_index    = '0;
      req_if.coef_value    = '0;
      req_if.history_newer = '0;
      req_if.history_older = '0;
      req_if.data_byte     = '0;
      rsp_if.ready         = 1'b0;

      foreach (book[i])
         book[i] = '0;
      foreach (codes[i])
         codes[i] = '0;
      hist_newer = '0;
      hist_older = '0;
      frame_pos  = 0;
      scale      = '0;
      pred_sel   = '0;

      // --- directed part ---
      push_load(7'd0,   16'h7fff);   // pred 0, order 0, tap 0 at max
      push_load(7'd8,   16'h8000);   // pred 0, order 1, tap 0 at min
      push_load(7'd127, 16'h8000);   // last entry of the codebook
      push_hist(16'h7fff, 16'h8000); // extreme history
      push_noise();                  // ignored action
      // frame with shift 0, predictor 0, extreme codes
      push_byte(8'h00);
      push_byte(8'h7f);
      push_byte(8'h80);
      push_byte(8'hff);
      push_byte(8'h08);
      push_byte(8'h77);
      push_byte(8'h88);
      push_byte(8'h00);
      push_byte(8'hf1);
      // wait for the samples, then a large scale with a predictor past the book
      drain_next = 1'b1;
      push_hist(16'h0000, 16'h0000);
      push_byte(8'hcf);
      push_byte(8'h7f);
      push_byte(8'h88);
      push_byte(8'h1e);
      push_byte(8'h80);
      // history mid-frame restarts at the header
      push_hist(16'h8000, 16'h7fff);
      push_byte(8'hf7);              // max shift, last predictor
      push_byte(8'h7f);
      push_byte(8'h80);
      push_byte(8'hff);
      push_byte(8'h01);

      // --- random part: mostly well-formed frames ---
      n = real_items + RANDOM_ITEMS;
      while (real_items < n) begin
         if ($urandom_range(0, 5) == 0)
            burst_mode = !burst_mode;
         if ($urandom_range(0, 14) == 0)
            drain_next = 1'b1;
         r = $urandom_range(0, 99);
         if (r < 10) begin
            repeat ($urandom_range(1, 6))
               push_load(INDEX_W'($urandom), rand_coef());
         end else if (r < 16) begin
            push_hist(rand_sample(), rand_sample());
         end else if (r < 19) begin
            push_noise();
         end else if (r < 23) begin
            // broken frame cut short by a history restart
            repeat ($urandom_range(1, 7))
               push_byte(BYTE_W'($urandom));
            push_hist(rand_sample(), rand_sample());
         end else begin
            sh = ($urandom_range(0, 9) == 0) ? NIB_W'($urandom_range(12, 15))
                                             : NIB_W'($urandom_range(0, 11));
            pd = ($urandom_range(0, 7) == 0) ? NIB_W'($urandom_range(8, 15))
                                             : NIB_W'($urandom_range(0, 7));
            push_byte({sh, pd});
            repeat (FRAME_END) begin
               if ($urandom_range(0, 19) == 0)
                  push_load(INDEX_W'($urandom), rand_coef());   // frame stays intact
               push_byte(BYTE_W'($urandom));
            end
         end
      end

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (accept_count != items_pushed)
         @(posedge clock);
      while (pcm_expected.size() != 0)
         @(posedge clock);
      repeat (END_SETTLE) @(posedge clock);

      if (errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Request driver: changes on the falling edge, one beat at a time
   // ---------------------------------------------------------------------
   int unsigned gap_left = 0;

   always @(negedge clock) begin : req_driver
      logic nxt_valid;
      if (!reset && !(req_if.valid && accept_count != issued_count)) begin
         nxt_valid = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending_beats.size() != 0 &&
                      !(pending_beats[0].drain && pcm_expected.size() != 0)) begin
            cur_req = pending_beats.pop_front();
            req_if.action        <= cur_req.action;
            req_if.coef_index    <= cur_req.coef_index;
            req_if.coef_value    <= cur_req.coef_value;
            req_if.history_newer <= cur_req.history_newer;
            req_if.history_older <= cur_req.history_older;
            req_if.data_byte     <= cur_req.data_byte;
            nxt_valid = 1'b1;
            issued_count++;
            gap_left = cur_req.gap;
         end
         req_if.valid <= nxt_valid;
      end
   end

   // ---------------------------------------------------------------------
   // Response pacing: random stall per beat, quiet stretches, one long hold
   // ---------------------------------------------------------------------
   int unsigned paced_count = 0;
   int unsigned stall_left  = 0;
   int unsigned hold_left   = 0;
   bit          hold_done   = 1'b0;

   always @(negedge clock) begin : rsp_pacer
      logic rdy;
      if (!reset) begin
         if (beat_count != paced_count) begin
            paced_count = beat_count;
            // every fourth stretch of 48 beats runs without stalls
            stall_left = (((beat_count / 48) % 4) == 3) ? 0 : $urandom_range(0, 4);
         end
         if (!hold_done && beat_count >= HOLD_AT_BEAT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;   // block fills up, input must back-pressure
         end
         if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rdy = 1'b0;
         end else begin
            rdy = 1'b1;
         end
         rsp_if.ready <= rdy;
      end
   end

   // ---------------------------------------------------------------------
   // Rising edge: check pcm beats, then predict for the accepted request
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : pcm_check
      pcm_beat_type e;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            beat_count <= beat_count + 1;
            if (pcm_expected.size() == 0) begin
               report_mismatch($sformatf("unexpected pcm beat %0d", rsp_if.pcm_sample));
            end else begin
               e = pcm_expected.pop_front();
               if (rsp_if.pcm_sample !== e.pcm || rsp_if.group_last !== e.group_last ||
                   rsp_if.frame_last !== e.frame_last)
                  report_mismatch($sformatf(
                     "beat %0d: pcm %0d/%0d group_last %b/%b frame_last %b/%b (got/exp)",
                     beat_count, rsp_if.pcm_sample, e.pcm, rsp_if.group_last,
                     e.group_last, rsp_if.frame_last, e.frame_last));
            end
         end
         if (req_if.valid && req_if.ready) begin
            accept_count <= accept_count + 1;
            predict_pcm(cur_req);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

endmodule
